// File: rtl/dawt_pkg.sv
// Shared constants and types for the device address whitelist table.
`default_nettype none

package dawt_pkg;

    localparam int ENTRIES  = 64;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int SLOT_W   = 6;
    localparam int ADDR_W   = 64;
    localparam int ROW_W    = 3 * ADDR_W;

    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_QUERY    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_KNOWN   = 2'd0,
        STATUS_UPDATED = 2'd1,
        STATUS_ADDED   = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// File: rtl/dawt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dawt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/device_address_whitelist_table_unit.sv
// Top level of the device address whitelist table: scan sequencer, valid marks, result register.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+---------------------------
//  request | action, hw_address, ip_high, ip_low      | req_valid / req_stall
//  result  | status, authorized, slot                 | res_valid / res_stall
//
// A request that adds an entry reads the entries of the table RAM in turn, compares each
// entry behind the RAM read latency, writes the new entry back, loads the result and
// returns to idle, where the next request is taken. A query, a known entry or a full
// table skips write-back; a hit ends the scan early. The single RAM read port and the
// one shared comparator set the pace of the scan. Reset clears the valid marks at once;
// no clearing pass. A stalled result is held while the next request is taken.
`default_nettype none

module device_address_whitelist_table_unit
    import dawt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic              action,
    input  wire logic [ADDR_W-1:0] hw_address,
    input  wire logic [ADDR_W-1:0] ip_high,
    input  wire logic [ADDR_W-1:0] ip_low,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output logic [1:0]             status,
    output logic                   authorized,
    output logic [SLOT_W-1:0]      slot
);

    state_t             state_reg, state_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic               res_valid_reg, res_valid_next;

    logic               act_reg, act_next;
    logic [ADDR_W-1:0]  hw_reg, hw_next;
    logic [ADDR_W-1:0]  iph_reg, iph_next;
    logic [ADDR_W-1:0]  ipl_reg, ipl_next;
    status_t            pend_status_reg, pend_status_next;
    logic               pend_auth_reg, pend_auth_next;
    logic [SLOT_W-1:0]  pend_slot_reg, pend_slot_next;
    status_t            res_status_reg, res_status_next;
    logic               res_auth_reg, res_auth_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;

    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ROW_W-1:0]   ram_rdata;

    logic               entry_live;
    logic               hw_eq;
    logic               ip_eq;
    logic               hit;
    logic               last;

    dawt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_idx_reg),
        .wr_data ({hw_reg, iph_reg, ipl_reg}),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // shared comparator on the entry read last cycle
    assign entry_live = valid_reg[cmp_idx_reg];
    assign hw_eq      = (ram_rdata[ROW_W-1 -: ADDR_W] == hw_reg);
    assign ip_eq      = (ram_rdata[2*ADDR_W-1:0] == {iph_reg, ipl_reg});
    assign hit        = cmp_vld_reg && entry_live && ((act_reg == ACT_QUERY) ? ip_eq : hw_eq);
    assign last       = cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign ram_raddr  = issue_cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        issue_cnt_next   = issue_cnt_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        wr_idx_next      = wr_idx_reg;
        res_valid_next   = res_valid_reg;
        act_next         = act_reg;
        hw_next          = hw_reg;
        iph_next         = iph_reg;
        ipl_next         = ipl_reg;
        pend_status_next = pend_status_reg;
        pend_auth_next   = pend_auth_reg;
        pend_slot_next   = pend_slot_reg;
        res_status_next  = res_status_reg;
        res_auth_next    = res_auth_reg;
        res_slot_next    = res_slot_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    act_next        = action;
                    hw_next         = hw_address;
                    iph_next        = ip_high;
                    ipl_next        = ip_low;
                    issue_cnt_next  = '0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_cnt_reg != CNT_W'(ENTRIES))
                begin
                    ram_re         = 1'b1;
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = ram_raddr;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (hit)
                begin
                    cmp_vld_next   = 1'b0;
                    pend_slot_next = SLOT_W'(cmp_idx_reg);
                    pend_auth_next = (act_reg == ACT_QUERY);
                    if (act_reg == ACT_REGISTER && !ip_eq)
                    begin
                        pend_status_next = STATUS_UPDATED;
                        wr_idx_next      = cmp_idx_reg;
                        state_next       = ST_WRITE;
                    end
                    else
                    begin
                        pend_status_next = STATUS_KNOWN;
                        state_next       = ST_RESP;
                    end
                end
                else if (cmp_vld_reg)
                begin
                    if (!entry_live && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (last)
                    begin
                        cmp_vld_next   = 1'b0;
                        pend_auth_next = 1'b0;
                        if (act_reg == ACT_QUERY)
                        begin
                            pend_status_next = STATUS_KNOWN;
                            pend_slot_next   = '0;
                            state_next       = ST_RESP;
                        end
                        else if (free_found_reg || !entry_live)
                        begin
                            wr_idx_next      = free_found_reg ? free_idx_reg : cmp_idx_reg;
                            pend_slot_next   = SLOT_W'(wr_idx_next);
                            pend_status_next = STATUS_ADDED;
                            state_next       = ST_WRITE;
                        end
                        else
                        begin
                            pend_status_next = STATUS_FULL;
                            pend_slot_next   = '0;
                            state_next       = ST_RESP;
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                ram_we                 = 1'b1;
                valid_next[wr_idx_reg] = 1'b1;
                state_next             = ST_RESP;
            end
            ST_RESP:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = pend_status_reg;
                    res_auth_next   = pend_auth_reg;
                    res_slot_next   = pend_slot_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            issue_cnt_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            issue_cnt_reg  <= issue_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg     <= cmp_idx_next;
        free_idx_reg    <= free_idx_next;
        wr_idx_reg      <= wr_idx_next;
        act_reg         <= act_next;
        hw_reg          <= hw_next;
        iph_reg         <= iph_next;
        ipl_reg         <= ipl_next;
        pend_status_reg <= pend_status_next;
        pend_auth_reg   <= pend_auth_next;
        pend_slot_reg   <= pend_slot_next;
        res_status_reg  <= res_status_next;
        res_auth_reg    <= res_auth_next;
        res_slot_reg    <= res_slot_next;
    end

    assign req_stall  = (state_reg != ST_IDLE);
    assign res_valid  = res_valid_reg;
    assign status     = res_status_reg;
    assign authorized = res_auth_reg;
    assign slot       = res_slot_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> valid_reg[$past(wr_idx_reg)])
        else $error("written entry not marked valid");

    a_auth_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_auth_reg) |-> (res_status_reg == STATUS_KNOWN))
        else $error("authorised result with register status");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_status_reg == STATUS_FULL) |-> (res_slot_reg == '0))
        else $error("table full result with non-zero slot");

endmodule

`default_nettype wire
